/* design/fsp_pkg.sv */
// Package: shared constants, types and decode helpers of the five-stage core.
`default_nettype none
package fsp_pkg;

  localparam int MEM_WORDS_DEF = 1024;
  localparam int REG_COUNT     = 8;
  localparam int REG_AW        = 3;
  localparam int INSTR_W       = 25;
  localparam int ADDR_W        = 10;
  localparam int WORD_W        = 32;

  typedef logic [INSTR_W-1:0] instr_t;
  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [REG_AW-1:0]  reg_idx_t;

  // request codes
  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_TICK = 2'd1,
    REQ_READ = 2'd2,
    REQ_NONE = 2'd3
  } req_op_t;

  // instruction opcodes
  localparam logic [2:0] OPC_ADD  = 3'd0;
  localparam logic [2:0] OPC_NOR  = 3'd1;
  localparam logic [2:0] OPC_LW   = 3'd2;
  localparam logic [2:0] OPC_SW   = 3'd3;
  localparam logic [2:0] OPC_BEQ  = 3'd4;
  localparam logic [2:0] OPC_HALT = 3'd6;
  localparam logic [2:0] OPC_NOOP = 3'd7;

  localparam instr_t NOOP_INSTR = {OPC_NOOP, 22'd0};

  function automatic logic [2:0] opc_of(input instr_t i);
    return i[24:22];
  endfunction

  function automatic reg_idx_t ra_of(input instr_t i);
    return i[21:19];
  endfunction

  function automatic reg_idx_t rb_of(input instr_t i);
    return i[18:16];
  endfunction

  function automatic logic writes_reg(input instr_t i);
    return (opc_of(i) == OPC_ADD) || (opc_of(i) == OPC_NOR) || (opc_of(i) == OPC_LW);
  endfunction

  function automatic reg_idx_t dest_of(input instr_t i);
    return (opc_of(i) == OPC_LW) ? i[18:16] : i[2:0];
  endfunction

  function automatic word_t sext16(input instr_t i);
    return {{16{i[15]}}, i[15:0]};
  endfunction

  // result record carried to the output register
  typedef struct packed {
    logic                halted;
    logic [ADDR_W-1:0]   pc;
    word_t               count;
    logic                wb_en;
    reg_idx_t            wb_reg;
    word_t               wb_val;
    logic                is_read;
  } resp_t;

endpackage
`default_nettype wire

/* design/five_stage_pipeline_cpu_top.sv */
// Top level: five-stage core with memories, forwarding and result register.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  request | in_valid in_ready in_op in_address      | in
//          | in_value                                |
//  result  | out_valid out_ready out_halted          | out
//          | out_prog_counter out_cycle_count        |
//          | out_wb_enable out_wb_register           |
//          | out_wb_value out_read_data              |
//
// One request is taken every cycle unless the result side stalls.
// Memories are read ahead from next-state addresses, so a tick finds
// its fetched word, load data and register operands ready.
// Reset (synchronous, rst_n low) returns the pipeline to noops, PC zero.
// A full result register stalls the request side through one skid stage.
// MEM_WORDS must be a power of two; addresses wrap on its low bits.
`default_nettype none
module five_stage_pipeline_cpu_top #(
  parameter int MEM_WORDS = fsp_pkg::MEM_WORDS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [1:0]             in_op,
  input  wire logic [9:0]             in_address,
  input  wire logic signed [31:0]     in_value,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        out_halted,
  output logic [9:0]                  out_prog_counter,
  output logic [31:0]                 out_cycle_count,
  output logic                        out_wb_enable,
  output logic [2:0]                  out_wb_register,
  output logic signed [31:0]          out_wb_value,
  output logic signed [31:0]          out_read_data
);
  import fsp_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);
  typedef logic [AW-1:0] maddr_t;

  // pipeline latches
  maddr_t   fetch_pc_r, fetch_pc_nxt;
  instr_t   ifid_ins_r, ifid_ins_nxt;
  maddr_t   ifid_pc_r, ifid_pc_nxt;
  instr_t   idex_ins_r, idex_ins_nxt;
  maddr_t   idex_pc_r, idex_pc_nxt;
  word_t    idex_a_r, idex_a_nxt;
  word_t    idex_b_r, idex_b_nxt;
  word_t    idex_off_r, idex_off_nxt;
  instr_t   exmem_ins_r, exmem_ins_nxt;
  maddr_t   exmem_tgt_r, exmem_tgt_nxt;
  word_t    exmem_alu_r, exmem_alu_nxt;
  word_t    exmem_st_r, exmem_st_nxt;
  instr_t   memwb_ins_r, memwb_ins_nxt;
  word_t    memwb_data_r, memwb_data_nxt;
  word_t    count_r, count_nxt;
  logic     halt_r, halt_nxt;
  logic [REG_COUNT-1:0] rf_vld_r, rf_vld_nxt;

  // result stages
  logic     s1_valid_r;
  resp_t    s1_r, s1_nxt;
  logic     out_valid_r;
  resp_t    out_r;
  word_t    out_rd_r;

  // memory ports
  logic     im_we, dm_we, rf_we;
  maddr_t   im_waddr, dm_waddr, im_raddr, dm_raddr;
  word_t    im_wdata, dm_wdata, rf_wdata;
  reg_idx_t rf_waddr, rf_ra_addr, rf_rb_addr;
  word_t    im_q, dm_q, dmr_q, rf_a_q, rf_b_q;
  logic     rd_en;

  logic     accept, tick, adv_out;

  // combinational work of a tick
  logic     taken, stall;
  logic [2:0] e_op, x_op, f_op;
  word_t    wdata, alu_out, va, vb;
  maddr_t   target;
  reg_idx_t ra, rb, xr, er;

  assign adv_out  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv_out;
  assign accept   = in_valid && in_ready;
  assign tick     = accept && (in_op == REQ_TICK) && !halt_r;
  assign rd_en    = accept && (in_op == REQ_READ);

  fsp_bram #(.WIDTH(INSTR_W), .DEPTH(MEM_WORDS)) u_imem (
    .clk(clk), .rst_n(rst_n), .we(im_we), .waddr(im_waddr),
    .wdata(im_wdata[INSTR_W-1:0]), .raddr(im_raddr), .rdata(im_q[INSTR_W-1:0])
  );
  assign im_q[WORD_W-1:INSTR_W] = '0;

  fsp_bram #(.WIDTH(WORD_W), .DEPTH(MEM_WORDS)) u_dmem_ld (
    .clk(clk), .rst_n(rst_n), .we(dm_we), .waddr(dm_waddr),
    .wdata(dm_wdata), .raddr(dm_raddr), .rdata(dm_q)
  );

  // copy of data memory that serves read requests
  fsp_ram #(.WIDTH(WORD_W), .DEPTH(MEM_WORDS)) u_dmem_rd (
    .clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
    .re(rd_en), .raddr(maddr_t'(in_address)), .rdata(dmr_q)
  );

  fsp_bram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_rf_a (
    .clk(clk), .rst_n(rst_n), .we(rf_we), .waddr(rf_waddr),
    .wdata(rf_wdata), .raddr(rf_ra_addr), .rdata(rf_a_q)
  );

  fsp_bram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_rf_b (
    .clk(clk), .rst_n(rst_n), .we(rf_we), .waddr(rf_waddr),
    .wdata(rf_wdata), .raddr(rf_rb_addr), .rdata(rf_b_q)
  );

  always_comb begin
    fetch_pc_nxt   = fetch_pc_r;
    ifid_ins_nxt   = ifid_ins_r;
    ifid_pc_nxt    = ifid_pc_r;
    idex_ins_nxt   = idex_ins_r;
    idex_pc_nxt    = idex_pc_r;
    idex_a_nxt     = idex_a_r;
    idex_b_nxt     = idex_b_r;
    idex_off_nxt   = idex_off_r;
    exmem_ins_nxt  = exmem_ins_r;
    exmem_tgt_nxt  = exmem_tgt_r;
    exmem_alu_nxt  = exmem_alu_r;
    exmem_st_nxt   = exmem_st_r;
    memwb_ins_nxt  = memwb_ins_r;
    memwb_data_nxt = memwb_data_r;
    count_nxt      = count_r;
    halt_nxt       = halt_r;
    rf_vld_nxt     = rf_vld_r;

    im_we    = 1'b0;
    im_waddr = maddr_t'(in_address);
    im_wdata = in_value;
    dm_we    = 1'b0;
    dm_waddr = maddr_t'(in_address);
    dm_wdata = in_value;
    rf_we    = 1'b0;
    rf_waddr = dest_of(memwb_ins_r);
    rf_wdata = memwb_data_r;

    taken   = 1'b0;
    stall   = 1'b0;
    e_op    = opc_of(exmem_ins_r);
    x_op    = opc_of(idex_ins_r);
    f_op    = opc_of(ifid_ins_r);
    ra      = ra_of(ifid_ins_r);
    rb      = rb_of(ifid_ins_r);
    xr      = dest_of(idex_ins_r);
    er      = dest_of(exmem_ins_r);
    wdata   = exmem_alu_r;
    alu_out = '0;
    target  = idex_pc_r + idex_off_r[AW-1:0];

    // write both memories on a load request
    if (accept && (in_op == REQ_LOAD)) begin
      im_we = 1'b1;
      dm_we = 1'b1;
    end

    if (tick) begin
      if (count_r != '1) begin
        count_nxt = count_r + 32'd1;
      end

      // write-back
      if (writes_reg(memwb_ins_r)) begin
        rf_we = 1'b1;
        rf_vld_nxt[rf_waddr] = 1'b1;
      end

      // memory stage
      case (e_op)
        OPC_LW: wdata = dm_q;
        OPC_SW: begin
          dm_we    = 1'b1;
          dm_waddr = exmem_alu_r[AW-1:0];
          dm_wdata = exmem_st_r;
        end
        OPC_BEQ: taken = (exmem_alu_r == '0);
        default: wdata = exmem_alu_r;
      endcase

      // execute
      case (x_op)
        OPC_ADD: alu_out = idex_a_r + idex_b_r;
        OPC_NOR: alu_out = ~(idex_a_r | idex_b_r);
        OPC_LW, OPC_SW: alu_out = idex_a_r + idex_off_r;
        OPC_BEQ: alu_out = idex_a_r - idex_b_r;
        default: alu_out = '0;
      endcase

      // decode: register file, then forward from WB, MEM, EX (youngest last)
      va = rf_vld_r[ra] ? rf_a_q : '0;
      vb = rf_vld_r[rb] ? rf_b_q : '0;
      if (writes_reg(memwb_ins_r)) begin
        if (rf_waddr == ra) va = memwb_data_r;
        if (rf_waddr == rb) vb = memwb_data_r;
      end
      if (writes_reg(exmem_ins_r)) begin
        if (er == ra) va = wdata;
        if (er == rb) vb = wdata;
      end
      if ((x_op == OPC_ADD) || (x_op == OPC_NOR)) begin
        if (xr == ra) va = alu_out;
        if (xr == rb) vb = alu_out;
      end
      if (x_op == OPC_LW) begin
        stall = ((f_op <= OPC_BEQ) && (xr == ra)) ||
                (((f_op == OPC_ADD) || (f_op == OPC_NOR) || (f_op == OPC_SW) ||
                  (f_op == OPC_BEQ)) && (xr == rb));
      end

      memwb_ins_nxt  = exmem_ins_r;
      memwb_data_nxt = wdata;
      if (taken) begin
        // redirect fetch and flush the three younger stages
        fetch_pc_nxt  = exmem_tgt_r;
        exmem_ins_nxt = NOOP_INSTR;
        exmem_tgt_nxt = '0;
        exmem_alu_nxt = '0;
        exmem_st_nxt  = '0;
        idex_ins_nxt  = NOOP_INSTR;
        idex_pc_nxt   = '0;
        idex_a_nxt    = '0;
        idex_b_nxt    = '0;
        idex_off_nxt  = '0;
        ifid_ins_nxt  = NOOP_INSTR;
        ifid_pc_nxt   = '0;
      end else begin
        exmem_ins_nxt = idex_ins_r;
        exmem_tgt_nxt = target;
        exmem_alu_nxt = alu_out;
        exmem_st_nxt  = idex_b_r;
        if (stall) begin
          idex_ins_nxt = NOOP_INSTR;
          idex_pc_nxt  = '0;
          idex_a_nxt   = '0;
          idex_b_nxt   = '0;
          idex_off_nxt = '0;
        end else begin
          idex_ins_nxt = ifid_ins_r;
          idex_pc_nxt  = ifid_pc_r;
          idex_a_nxt   = va;
          idex_b_nxt   = vb;
          idex_off_nxt = sext16(ifid_ins_r);
          ifid_ins_nxt = im_q[INSTR_W-1:0];
          ifid_pc_nxt  = fetch_pc_r + maddr_t'(1);
          fetch_pc_nxt = fetch_pc_r + maddr_t'(1);
        end
      end
      halt_nxt = (opc_of(exmem_ins_r) == OPC_HALT);
    end

    // read ahead from the next-state addresses
    im_raddr   = rst_n ? fetch_pc_nxt : '0;
    dm_raddr   = rst_n ? exmem_alu_nxt[AW-1:0] : '0;
    rf_ra_addr = rst_n ? ra_of(ifid_ins_nxt) : '0;
    rf_rb_addr = rst_n ? rb_of(ifid_ins_nxt) : '0;

    s1_nxt.halted  = halt_nxt;
    s1_nxt.pc      = ADDR_W'(fetch_pc_nxt);
    s1_nxt.count   = count_nxt;
    s1_nxt.wb_en   = rf_we;
    s1_nxt.wb_reg  = rf_we ? rf_waddr : '0;
    s1_nxt.wb_val  = rf_we ? rf_wdata : '0;
    s1_nxt.is_read = rd_en;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fetch_pc_r   <= '0;
      ifid_ins_r   <= NOOP_INSTR;
      ifid_pc_r    <= '0;
      idex_ins_r   <= NOOP_INSTR;
      idex_pc_r    <= '0;
      idex_a_r     <= '0;
      idex_b_r     <= '0;
      idex_off_r   <= '0;
      exmem_ins_r  <= NOOP_INSTR;
      exmem_tgt_r  <= '0;
      exmem_alu_r  <= '0;
      exmem_st_r   <= '0;
      memwb_ins_r  <= NOOP_INSTR;
      memwb_data_r <= '0;
      count_r      <= '0;
      halt_r       <= 1'b0;
      rf_vld_r     <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      fetch_pc_r   <= fetch_pc_nxt;
      ifid_ins_r   <= ifid_ins_nxt;
      ifid_pc_r    <= ifid_pc_nxt;
      idex_ins_r   <= idex_ins_nxt;
      idex_pc_r    <= idex_pc_nxt;
      idex_a_r     <= idex_a_nxt;
      idex_b_r     <= idex_b_nxt;
      idex_off_r   <= idex_off_nxt;
      exmem_ins_r  <= exmem_ins_nxt;
      exmem_tgt_r  <= exmem_tgt_nxt;
      exmem_alu_r  <= exmem_alu_nxt;
      exmem_st_r   <= exmem_st_nxt;
      memwb_ins_r  <= memwb_ins_nxt;
      memwb_data_r <= memwb_data_nxt;
      count_r      <= count_nxt;
      halt_r       <= halt_nxt;
      rf_vld_r     <= rf_vld_nxt;
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (adv_out) begin
        s1_valid_r <= 1'b0;
      end
      if (adv_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload: advance stage one into the output register
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
    if (adv_out) begin
      out_r    <= s1_r;
      out_rd_r <= s1_r.is_read ? dmr_q : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_halted       = out_r.halted;
  assign out_prog_counter = out_r.pc;
  assign out_cycle_count  = out_r.count;
  assign out_wb_enable    = out_r.wb_en;
  assign out_wb_register  = out_r.wb_reg;
  assign out_wb_value     = out_r.wb_val;
  assign out_read_data    = out_rd_r;

  // a halted core stays halted
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r) else $error("halt flag dropped");

  // only a tick moves the cycle count, by one
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !tick |=> count_r == $past(count_r)) else $error("count moved without tick");

  // a taken branch flushes decode and execute
  a_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (tick && taken) |=> (ifid_ins_r == NOOP_INSTR) && (idex_ins_r == NOOP_INSTR))
    else $error("branch flush missed");

  // a load-use stall leaves fetch in place
  a_stall_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (tick && stall && !taken) |=> fetch_pc_r == $past(fetch_pc_r))
    else $error("fetch advanced during stall");
endmodule
`default_nettype wire

/* design/fsp_ram.sv */
// Generic synchronous RAM: one write port, one registered read port.
`default_nettype none
module fsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

/* design/fsp_bram.sv */
// RAM read every cycle with write-to-read bypass for same-cycle collisions.
`default_nettype none
module fsp_bram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] ram_q;
  logic             hit_r;
  logic [WIDTH-1:0] byp_r;

  fsp_ram #(.WIDTH(WIDTH), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (1'b1),
    .raddr (raddr),
    .rdata (ram_q)
  );

  // hold the written word when it lands on the address being read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= we && (waddr == raddr);
    end
    byp_r <= wdata;
  end

  assign rdata = hit_r ? byp_r : ram_q;
endmodule
`default_nettype wire

/* tb/five_stage_pipeline_cpu_top_tb.sv */
// Testbench: self-checking stimulus and cycle-true pipeline prediction for the five-stage core.
`timescale 1ns / 1ps
module five_stage_pipeline_cpu_top_tb;
  import fsp_pkg::*;

  // jalr has no package constant; the core runs it as a noop
  localparam logic [2:0] OPC_JALR = 3'd5;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         RANDOM_ITEMS = 200;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_op;
  logic [9:0]  in_address;
  logic [31:0] in_value;
  logic        out_valid;
  logic        out_ready;
  logic        out_halted;
  logic [9:0]  out_prog_counter;
  logic [31:0] out_cycle_count;
  logic        out_wb_enable;
  logic [2:0]  out_wb_register;
  logic [31:0] out_wb_value;
  logic [31:0] out_read_data;

  five_stage_pipeline_cpu_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_address       (in_address),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_halted       (out_halted),
    .out_prog_counter (out_prog_counter),
    .out_cycle_count  (out_cycle_count),
    .out_wb_enable    (out_wb_enable),
    .out_wb_register  (out_wb_register),
    .out_wb_value     (out_wb_value),
    .out_read_data    (out_read_data)
  );

  // One expected response per accepted request
  typedef struct {
    logic        halted;
    logic [9:0]  pc;
    logic [31:0] count;
    logic        wb_en;
    logic [2:0]  wb_reg;
    logic [31:0] wb_val;
    logic [31:0] rdata;
  } status_t;

  status_t status_q[$];

  // Shadow machine state, updated once per accepted load or tick request
  logic [31:0] regs [8];
  logic [31:0] imem [1024];
  logic [31:0] dmem [1024];
  logic [9:0]  fetch_pc;
  logic [31:0] fd_instr, fd_npc;
  logic [31:0] dx_instr, dx_npc, dx_a, dx_b, dx_off;
  logic [31:0] xm_instr, xm_target, xm_alu, xm_sdata;
  logic [31:0] mw_instr, mw_data;
  logic [31:0] ticks;
  logic        machine_halted;

  int  mismatches;
  int  cycles;
  bit  calm;   // when set, both sides run without gaps

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("five_stage_pipeline_cpu_top test failed");
      $finish;
    end
  end

  function automatic bit dest_of_word(input logic [31:0] w, output logic [2:0] r);
    logic [2:0] o;
    o = w[24:22];
    r = (o == OPC_LW) ? w[18:16] : w[2:0];
    return (o == OPC_ADD) || (o == OPC_NOR) || (o == OPC_LW);
  endfunction

  // Advance every stage once, in write-back first order
  task automatic run_tick(inout status_t s);
    logic [2:0]  r, xo, fo, ra, rb, mo;
    logic [31:0] wdata, alu_out, va, vb, fetched;
    logic [9:0]  target, npc;
    bit          taken, stall;
    taken = 0;
    stall = 0;
    if (ticks != 32'hFFFF_FFFF) ticks++;
    if (dest_of_word(mw_instr, r)) begin
      regs[r] = mw_data;
      s.wb_en = 1'b1;
      s.wb_reg = r;
      s.wb_val = mw_data;
    end
    // memory stage
    mo = xm_instr[24:22];
    wdata = xm_alu;
    if (mo == OPC_LW) wdata = dmem[xm_alu[9:0]];
    else if (mo == OPC_SW) dmem[xm_alu[9:0]] = xm_sdata;
    else if (mo == OPC_BEQ) taken = (xm_alu == 32'd0);
    // execute stage
    xo = dx_instr[24:22];
    case (xo)
      OPC_ADD: alu_out = dx_a + dx_b;
      OPC_NOR: alu_out = ~(dx_a | dx_b);
      OPC_LW, OPC_SW: alu_out = dx_a + dx_off;
      OPC_BEQ: alu_out = dx_a - dx_b;
      default: alu_out = 32'd0;
    endcase
    target = 10'(dx_npc + dx_off);
    // decode with forwarding; the younger producer overrides
    fo = fd_instr[24:22];
    ra = fd_instr[21:19];
    rb = fd_instr[18:16];
    va = regs[ra];
    vb = regs[rb];
    if (dest_of_word(xm_instr, r)) begin
      if (r == ra) va = wdata;
      if (r == rb) vb = wdata;
    end
    if (xo == OPC_ADD || xo == OPC_NOR) begin
      r = dx_instr[2:0];
      if (r == ra) va = alu_out;
      if (r == rb) vb = alu_out;
    end
    if (xo == OPC_LW) begin
      r = dx_instr[18:16];
      stall = (fo <= OPC_BEQ && r == ra) ||
              ((fo == OPC_ADD || fo == OPC_NOR || fo == OPC_SW || fo == OPC_BEQ) && r == rb);
    end
    fetched = imem[fetch_pc];
    npc = fetch_pc + 10'd1;
    mw_instr = xm_instr;
    mw_data = wdata;
    if (taken) begin
      // branch wins over any stall: flush three stages
      fetch_pc = xm_target[9:0];
      xm_instr = 32'(NOOP_INSTR); xm_target = 0; xm_alu = 0; xm_sdata = 0;
      dx_instr = 32'(NOOP_INSTR); dx_npc = 0; dx_a = 0; dx_b = 0; dx_off = 0;
      fd_instr = 32'(NOOP_INSTR); fd_npc = 0;
    end else begin
      xm_instr = dx_instr;
      xm_target = 32'(target);
      xm_alu = alu_out;
      xm_sdata = dx_b;
      if (stall) begin
        dx_instr = 32'(NOOP_INSTR); dx_npc = 0; dx_a = 0; dx_b = 0; dx_off = 0;
      end else begin
        dx_instr = fd_instr;
        dx_npc = fd_npc;
        dx_a = va;
        dx_b = vb;
        dx_off = {{16{fd_instr[15]}}, fd_instr[15:0]};
        fd_instr = fetched;
        fd_npc = 32'(npc);
        fetch_pc = npc;
      end
    end
    machine_halted = (mw_instr[24:22] == OPC_HALT);
  endtask

  // Work out the response to one accepted request and queue it
  task automatic predict_status(input logic [1:0] op, input logic [9:0] addr,
                                input logic [31:0] val);
    status_t s;
    s = '{default: '0};
    if (op == REQ_LOAD) begin
      imem[addr] = val;
      dmem[addr] = val;
    end else if (op == REQ_READ) begin
      s.rdata = dmem[addr];
    end else if (op == REQ_TICK && !machine_halted) begin
      run_tick(s);
    end
    s.halted = machine_halted;
    s.pc = fetch_pc;
    s.count = ticks;
    status_q.push_back(s);
  endtask

  // Send one request: optional gap, then hold valid until accepted
  task automatic send_request(input logic [1:0] op, input logic [9:0] addr,
                              input logic [31:0] val);
    int gap;
    gap = calm ? 0 : $urandom_range(9);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_op = op;
    in_address = addr;
    in_value = val;
    in_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    predict_status(op, addr, val);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Random instruction word; halt never appears here
  function automatic logic [31:0] rand_instr();
    logic [31:0] w;
    int pick;
    w = $urandom;
    pick = $urandom_range(99);
    if (pick < 22) w[24:22] = OPC_ADD;
    else if (pick < 36) w[24:22] = OPC_NOR;
    else if (pick < 56) w[24:22] = OPC_LW;
    else if (pick < 70) w[24:22] = OPC_SW;
    else if (pick < 84) w[24:22] = OPC_BEQ;
    else if (pick < 88) w[24:22] = OPC_JALR;
    else w[24:22] = OPC_NOOP;
    // keep most branches short so loops stay local
    if (w[24:22] == OPC_BEQ && $urandom_range(3) != 0)
      w[15:0] = 16'($signed($urandom_range(8)) - 4);
    return w;
  endfunction

  function automatic logic [31:0] encode(input logic [2:0] opc, input logic [2:0] ra,
                                         input logic [2:0] rb, input logic [15:0] field);
    return {7'd0, opc, ra, rb, field};
  endfunction

  // Compare each accepted response with the oldest prediction
  always @(posedge clk) begin
    status_t e;
    if (rst_n && out_valid && out_ready) begin
      if (status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response at cycle %0d", cycles);
      end else begin
        e = status_q.pop_front();
        if (out_halted !== e.halted || out_prog_counter !== e.pc ||
            out_cycle_count !== e.count || out_wb_enable !== e.wb_en ||
            out_wb_register !== e.wb_reg || out_wb_value !== e.wb_val ||
            out_read_data !== e.rdata) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp h%0b pc%0d n%0d wb%0b r%0d v%h rd%h",
                     e.halted, e.pc, e.count, e.wb_en, e.wb_reg, e.wb_val, e.rdata);
            $display("          got h%0b pc%0d n%0d wb%0b r%0d v%h rd%h",
                     out_halted, out_prog_counter, out_cycle_count, out_wb_enable,
                     out_wb_register, out_wb_value, out_read_data);
          end
        end
      end
    end
  end

  // Response side: random stall before each response
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = calm ? 0 : $urandom_range(9);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      forever begin
        @(posedge clk);
        if (out_valid) break;
      end
    end
  end

  // Fill both memories so no fetch or load ever reads an unwritten word
  task automatic test_fill_memory();
    calm = 1;
    for (int a = 0; a < 1024; a++) send_request(REQ_LOAD, 10'(a), rand_instr());
    calm = 0;
  endtask

  // Short program: load-use stall, forwarding, store then load, taken branch
  task automatic test_hazards();
    send_request(REQ_LOAD, 10'd20, 32'h8000_0000);
    send_request(REQ_LOAD, 10'd1023, 32'h7FFF_FFFF);
    send_request(REQ_LOAD, 10'd0, encode(OPC_LW,   3'd0, 3'd1, 16'd20));
    send_request(REQ_LOAD, 10'd1, encode(OPC_ADD,  3'd1, 3'd1, 16'd2));
    send_request(REQ_LOAD, 10'd2, encode(OPC_NOR,  3'd2, 3'd1, 16'd3));
    send_request(REQ_LOAD, 10'd3, encode(OPC_SW,   3'd0, 3'd3, 16'd21));
    send_request(REQ_LOAD, 10'd4, encode(OPC_LW,   3'd0, 3'd4, 16'd21));
    send_request(REQ_LOAD, 10'd5, encode(OPC_BEQ,  3'd4, 3'd3, 16'd2));
    send_request(REQ_LOAD, 10'd8, encode(OPC_ADD,  3'd1, 3'd2, 16'd0));
    send_request(REQ_LOAD, 10'd9, encode(OPC_JALR, 3'd7, 3'd7, 16'hFFFF));
    repeat (14) send_request(REQ_TICK, 10'd0, 32'hFFFF_FFFF);
    send_request(REQ_READ, 10'd21, 32'd0);
    send_request(REQ_READ, 10'd1023, 32'd0);
    send_request(REQ_NONE, 10'h3FF, 32'hFFFF_FFFF);
  endtask

  // Mostly ticks over a random program, with loads, reads and idle codes mixed in
  task automatic test_random_program();
    int pick;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 50) calm = ~calm;
      pick = $urandom_range(99);
      if (pick < 60) send_request(REQ_TICK, 10'($urandom), $urandom);
      else if (pick < 78)
        send_request(REQ_LOAD, 10'($urandom), ($urandom_range(1)) ? rand_instr() : $urandom);
      else if (pick < 95) send_request(REQ_READ, 10'($urandom), $urandom);
      else send_request(REQ_NONE, 10'($urandom), $urandom);
      if (n == RANDOM_ITEMS / 2) test_drain_pause();
    end
    calm = 0;
  endtask

  // Hold the request side until every response is back
  task automatic test_drain_pause();
    in_valid = 1'b0;
    wait (status_q.size() == 0);
    @(negedge clk);
  endtask

  // Plant halts at the fetch point until one retires, then poke the frozen core
  task automatic test_halt();
    for (int g = 0; g < 40 && !machine_halted; g++) begin
      for (int k = 0; k < 4; k++)
        send_request(REQ_LOAD, fetch_pc + 10'(k), encode(OPC_HALT, 3'd0, 3'd0, 16'd0));
      send_request(REQ_TICK, 10'd0, 32'd0);
    end
    repeat (4) send_request(REQ_TICK, 10'd0, 32'd0);
    send_request(REQ_READ, 10'($urandom), 32'd0);
  endtask

  initial begin
    for (int r = 0; r < 8; r++) regs[r] = '0;
    fetch_pc = '0;
    fd_instr = 32'(NOOP_INSTR); fd_npc = 0;
    dx_instr = 32'(NOOP_INSTR); dx_npc = 0; dx_a = 0; dx_b = 0; dx_off = 0;
    xm_instr = 32'(NOOP_INSTR); xm_target = 0; xm_alu = 0; xm_sdata = 0;
    mw_instr = 32'(NOOP_INSTR); mw_data = 0;
    ticks = 0;
    machine_halted = 0;
    mismatches = 0;
    cycles = 0;
    calm = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = REQ_NONE;
    in_address = '0;
    in_value = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_fill_memory();
    test_hazards();
    test_random_program();
    test_halt();

    // drain, then allow the result pipeline to settle
    wait (status_q.size() == 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && status_q.size() == 0) begin
      $display("five_stage_pipeline_cpu_top test passed");
    end else begin
      $display("five_stage_pipeline_cpu_top test failed");
    end
    $finish;
  end

endmodule
